### hdl/loc_pkg.sv
// Package for the lock order checker: beat types, sequencer states and
// default parameter values. No dependencies.
`timescale 1ns / 1ps

package loc_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int LEVEL_BITS_DEFAULT = 8;

	localparam logic MODE_ACQUIRE = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] level;
	} loc_in_t;

	typedef struct packed {
		logic       violation;
		logic [7:0] conflict_level;
		logic       dropped;
		logic       release_missed;
		logic [4:0] held_count;
	} loc_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_APPEND,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DONE
	} loc_state_t;

endpackage

### hdl/loc_ram.sv
// Single write port, single read port memory for the held lock levels.
// Read data is registered. Depends on nothing.
`timescale 1ns / 1ps

module loc_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/loc_cmp.sv
// Shared compare unit: checks one stored level against the event level.
// Gives greater-or-equal for acquires and equality for releases.
`timescale 1ns / 1ps

module loc_cmp #(
	parameter int WIDTH = 8
) (
	input  logic             mode,
	input  logic [WIDTH-1:0] stored,
	input  logic [WIDTH-1:0] level,
	output logic             hit
);

	import loc_pkg::*;

	always_comb begin
		if (mode == MODE_RELEASE) begin
			hit = (stored == level);
		end else begin
			hit = (stored >= level);
		end
	end

endmodule

### hdl/loc_ctrl.sv
// Sequencer for the lock order checker: scans, appends and compacts the held
// list one entry at a time. Uses loc_pkg, loc_ram and loc_cmp.
`timescale 1ns / 1ps

module loc_ctrl #(
	parameter int DEPTH      = 16,
	parameter int LEVEL_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  loc_pkg::loc_in_t  req,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_ready,
	output loc_pkg::loc_out_t res
);

	import loc_pkg::*;

	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	loc_state_t state_q, state_n;

	logic                  mode_q, mode_n;
	logic [LEVEL_BITS-1:0] lvl_q, lvl_n;
	logic [CNT_W-1:0]      total_q, total_n;
	logic [CNT_W-1:0]      idx_q, idx_n;
	logic                  viol_q, viol_n;
	logic [LEVEL_BITS-1:0] conf_q, conf_n;
	logic                  drop_q, drop_n;
	logic                  miss_q, miss_n;

	logic [CNT_W-1:0]      scan_pos;
	logic                  we;
	logic [IW-1:0]         waddr;
	logic [LEVEL_BITS-1:0] wdata;
	logic [IW-1:0]         raddr;
	logic [LEVEL_BITS-1:0] rdata;
	logic                  hit;
	logic [31:0]           conf_wide;
	logic [31:0]           total_wide;

	loc_ram #(
		.DEPTH(DEPTH),
		.WIDTH(LEVEL_BITS),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	loc_cmp #(
		.WIDTH(LEVEL_BITS)
	) u_cmp (
		.mode  (mode_q),
		.stored(rdata),
		.level (lvl_q),
		.hit   (hit)
	);

	assign scan_pos = (mode_q == MODE_RELEASE) ? idx_q - CNT_W'(1) : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
		end else begin
			state_q <= state_n;
			total_q <= total_n;
		end
	end

	always_ff @(posedge clk) begin
		mode_q <= mode_n;
		lvl_q  <= lvl_n;
		idx_q  <= idx_n;
		viol_q <= viol_n;
		conf_q <= conf_n;
		drop_q <= drop_n;
		miss_q <= miss_n;
	end

	always_comb begin
		state_n   = state_q;
		mode_n    = mode_q;
		lvl_n     = lvl_q;
		total_n   = total_q;
		idx_n     = idx_q;
		viol_n    = viol_q;
		conf_n    = conf_q;
		drop_n    = drop_q;
		miss_n    = miss_q;
		we        = 1'b0;
		waddr     = '0;
		wdata     = lvl_q;
		raddr     = '0;
		idle      = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					mode_n = req.mode;
					lvl_n  = LEVEL_BITS'(req.level);
					viol_n = 1'b0;
					conf_n = '0;
					drop_n = 1'b0;
					miss_n = (req.mode == MODE_RELEASE);
					if (req.mode == MODE_RELEASE) begin
						idx_n   = total_q;
						state_n = (total_q == '0) ? ST_DONE : ST_SCAN_RD;
					end else begin
						idx_n   = '0;
						state_n = (total_q == '0) ? ST_APPEND : ST_SCAN_RD;
					end
				end
			end
			ST_SCAN_RD: begin
				raddr   = scan_pos[IW-1:0];
				state_n = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (mode_q == MODE_RELEASE) begin
					idx_n = scan_pos;
					if (hit) begin
						miss_n = 1'b0;
						if (idx_q < total_q) begin
							state_n = ST_SHIFT_RD;
						end else begin
							total_n = total_q - CNT_W'(1);
							state_n = ST_DONE;
						end
					end else if (scan_pos == '0) begin
						state_n = ST_DONE;
					end else begin
						state_n = ST_SCAN_RD;
					end
				end else begin
					if (hit) begin
						viol_n  = 1'b1;
						conf_n  = rdata;
						state_n = ST_APPEND;
					end else begin
						idx_n   = idx_q + CNT_W'(1);
						state_n = (idx_q + CNT_W'(1) == total_q) ? ST_APPEND : ST_SCAN_RD;
					end
				end
			end
			ST_APPEND: begin
				if (total_q < CNT_W'(DEPTH)) begin
					we      = 1'b1;
					waddr   = total_q[IW-1:0];
					total_n = total_q + CNT_W'(1);
				end else begin
					drop_n = 1'b1;
				end
				state_n = ST_DONE;
			end
			ST_SHIFT_RD: begin
				raddr   = IW'(idx_q + CNT_W'(1));
				state_n = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				we    = 1'b1;
				waddr = idx_q[IW-1:0];
				wdata = rdata;
				idx_n = idx_q + CNT_W'(1);
				if (idx_q + CNT_W'(2) < total_q) begin
					state_n = ST_SHIFT_RD;
				end else begin
					total_n = total_q - CNT_W'(1);
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign conf_wide  = 32'(conf_q);
	assign total_wide = 32'(total_q);

	always_comb begin
		res.violation      = viol_q;
		res.conflict_level = conf_wide[7:0];
		res.dropped        = drop_q;
		res.release_missed = miss_q;
		res.held_count     = total_wide[4:0];
	end

endmodule

### hdl/lock_order_checker.sv
// Top level of the lock order checker: input handshake, output register and
// checks. Uses loc_pkg and loc_ctrl.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   input   | in_valid, in_stall, in_data       | in
//   output  | out_valid, out_stall, out_data    | out
//
// An acquire compares held entries in turn until a hit or the end of the list; a
// release compares from the top down, then moves the entries above its hit down.
// The held list's single read port feeds the compare unit one entry at a time.
// Reset clears the held count; the list itself needs no clearing pass.
// A waiting result sits in the output register while the next beat is taken.
`timescale 1ns / 1ps

module lock_order_checker #(
	parameter int DEPTH      = loc_pkg::DEPTH_DEFAULT,
	parameter int LEVEL_BITS = loc_pkg::LEVEL_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  loc_pkg::loc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output loc_pkg::loc_out_t out_data
);

	import loc_pkg::*;

	logic     idle;
	logic     start;
	logic     res_valid;
	logic     res_ready;
	loc_out_t res;
	logic     out_valid_q;
	loc_out_t out_data_q;

	assign in_stall  = !idle;
	assign start     = in_valid && idle;
	assign res_ready = !out_valid_q || !out_stall;

	loc_ctrl #(
		.DEPTH     (DEPTH),
		.LEVEL_BITS(LEVEL_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (in_data),
		.idle     (idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a beat is still in work");

	a_release_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.release_missed) |-> (!out_data.violation && !out_data.dropped))
		else $error("release beat carries acquire flags");

	a_conflict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.violation) |-> (out_data.conflict_level == 8'd0))
		else $error("conflict level set without a violation");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (DEPTH < 32)) |-> (32'(out_data.held_count) <= 32'(DEPTH)))
		else $error("held count above list depth");

endmodule

### tb/lock_order_checker_tb.sv
// Self-checking testbench for lock_order_checker: directed and random acquire and release beats,
// checked against an in-bench model of the held-level list. Depends on loc_pkg and the RTL.
`timescale 1ns / 1ps

module lock_order_checker_tb;
	import loc_pkg::*;

	localparam int DEPTH        = DEPTH_DEFAULT;
	localparam int LEVEL_BITS   = LEVEL_BITS_DEFAULT;
	localparam int MAX_LATENCY  = 4 * DEPTH + 3;
	localparam int RANDOM_ITEMS = 1400;
	localparam int QUIET_TAIL   = 150;
	localparam logic [7:0] LEVEL_MASK = 8'((64'd1 << LEVEL_BITS) - 64'd1);

	typedef struct packed {
		logic [DEPTH-1:0][7:0] levels;
		int                    total;
	} held_list_t;

	typedef struct packed {
		logic    hold_first;
		loc_in_t ev;
	} pending_t;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_stall;
	loc_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	loc_out_t out_data;

	pending_t   lock_events[$];
	loc_out_t   expected_reports[$];
	held_list_t plan_list;
	held_list_t dut_list;
	pending_t   next_event;
	loc_out_t   want;
	logic       hold_next;
	logic       quiet = 1'b0;
	int         send_gap;
	int         stall_left;
	int         events_taken;
	int         reports_seen;
	int         errors;

	lock_order_checker #(
		.DEPTH      (DEPTH),
		.LEVEL_BITS (LEVEL_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	function automatic loc_out_t predict_event(inout held_list_t st, input loc_in_t ev);
		loc_out_t   rpt;
		logic [7:0] lvl;
		int         i;
		int         hit;
		rpt = '0;
		lvl = ev.level & LEVEL_MASK;
		if (ev.mode == MODE_ACQUIRE) begin
			for (i = 0; i < st.total && !rpt.violation; i++) begin
				if (st.levels[i] >= lvl) begin
					rpt.violation      = 1'b1;
					rpt.conflict_level = st.levels[i];
				end
			end
			if (st.total < DEPTH) begin
				st.levels[st.total] = lvl;
				st.total++;
			end else begin
				rpt.dropped = 1'b1;
			end
		end else begin
			hit = -1;
			for (i = st.total - 1; i >= 0 && hit < 0; i--) begin
				if (st.levels[i] == lvl)
					hit = i;
			end
			if (hit < 0) begin
				rpt.release_missed = 1'b1;
			end else begin
				for (i = hit; i + 1 < st.total; i++)
					st.levels[i] = st.levels[i + 1];
				st.total--;
			end
		end
		rpt.held_count = 5'(st.total);
		return rpt;
	endfunction

	task automatic queue_event(input logic mode, input int level);
		pending_t p;
		p.hold_first = hold_next;
		p.ev.mode    = mode;
		p.ev.level   = 8'(level);
		hold_next    = 1'b0;
		void'(predict_event(plan_list, p.ev));
		lock_events.push_back(p);
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			quiet    <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_reports.push_back(predict_event(dut_list, in_data));
				events_taken++;
			end
			quiet <= (lock_events.size() < QUIET_TAIL);
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (lock_events.size() == 0 ||
					(lock_events[0].hold_first && events_taken != reports_seen)) begin
				in_valid <= 1'b0;
			end else begin
				next_event = lock_events.pop_front();
				in_valid <= 1'b1;
				in_data  <= next_event.ev;
				if (!quiet && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 16);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall    <= 1'b0;
			reports_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				reports_seen <= reports_seen + 1;
				if (expected_reports.size() == 0) begin
					$display("%0t: result beat with nothing expected: expected none, actual %p",
						$time, out_data);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					check_field("violation", int'(want.violation),
						int'(out_data.violation));
					check_field("conflict_level", int'(want.conflict_level),
						int'(out_data.conflict_level));
					check_field("dropped", int'(want.dropped),
						int'(out_data.dropped));
					check_field("release_missed", int'(want.release_missed),
						int'(out_data.release_missed));
					check_field("held_count", int'(want.held_count),
						int'(out_data.held_count));
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 16);
			end
		end
	end

	initial begin
		int k;
		int n;
		int kind;
		int top;
		int idx;
		int directed_n;
		bit mid_paused;
		int acquired[$];

		plan_list  = '0;
		dut_list   = '0;
		hold_next  = 1'b0;
		mid_paused = 1'b0;
		send_gap   = 0;
		stall_left = 0;
		events_taken = 0;
		errors     = 0;

		// Directed: empty release, equal levels, extremes, a full list, duplicates and shifts.
		queue_event(MODE_RELEASE, 7);
		queue_event(MODE_ACQUIRE, 0);
		queue_event(MODE_ACQUIRE, 0);
		queue_event(MODE_ACQUIRE, 255);
		for (k = 0; k < DEPTH - 3; k++)
			queue_event(MODE_ACQUIRE, 10 + k);
		queue_event(MODE_ACQUIRE, 1);
		queue_event(MODE_RELEASE, 0);
		queue_event(MODE_RELEASE, 255);
		queue_event(MODE_RELEASE, 200);
		queue_event(MODE_RELEASE, 10 + DEPTH - 4);
		directed_n = lock_events.size();
		hold_next  = 1'b1;

		while (lock_events.size() < directed_n + RANDOM_ITEMS) begin
			if (!mid_paused && lock_events.size() > directed_n + RANDOM_ITEMS / 2) begin
				hold_next  = 1'b1;
				mid_paused = 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind <= 4) begin
				top = -1;
				for (k = 0; k < plan_list.total; k++)
					if (int'(plan_list.levels[k]) > top)
						top = int'(plan_list.levels[k]);
				acquired.delete();
				n = $urandom_range(1, 6);
				for (k = 0; k < n && top < 255; k++) begin
					top = $urandom_range(top + 1, (top + 24 > 255) ? 255 : top + 24);
					queue_event(MODE_ACQUIRE, top);
					acquired.push_back(top);
					if ($urandom_range(0, 4) == 0) begin
						idx = $urandom_range(0, top);
						queue_event(MODE_ACQUIRE, idx);
						acquired.push_back(idx);
					end
				end
				if ($urandom_range(0, 3) != 0) begin
					if ($urandom_range(0, 1) == 0) begin
						while (acquired.size() > 0)
							queue_event(MODE_RELEASE, acquired.pop_back());
					end else begin
						while (acquired.size() > 0) begin
							idx = $urandom_range(0, acquired.size() - 1);
							queue_event(MODE_RELEASE, acquired[idx]);
							acquired.delete(idx);
						end
					end
				end
			end else if (kind == 5) begin
				n = plan_list.total;
				for (k = 0; k < n; k++) begin
					idx = $urandom_range(0, plan_list.total - 1);
					queue_event(MODE_RELEASE, int'(plan_list.levels[idx]));
				end
			end else if (kind == 6) begin
				n = $urandom_range(DEPTH - plan_list.total, DEPTH - plan_list.total + 3);
				for (k = 0; k < n; k++)
					queue_event(MODE_ACQUIRE, $urandom_range(0, 255));
			end else if (kind == 7) begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					queue_event(MODE_RELEASE, $urandom_range(0, 255));
			end else begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					queue_event(logic'($urandom_range(0, 1)), $urandom_range(0, 255));
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (lock_events.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (MAX_LATENCY + 8) @(posedge clk);

		if (expected_reports.size() != 0) begin
			$display("%0t: results still expected at end: expected %0d more, actual 0",
				$time, expected_reports.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
